@@ rtl/core/mfd_pkg.sv @@
// Shared types and constants for the meter frame deframer.
// Used by mfd_parser and meter_frame_deframer_top; depends on nothing else.
package mfd_pkg;

    // Framing bytes
    localparam logic [7:0] SOF_BYTE  = 8'h68;
    localparam logic [7:0] STOP_BYTE = 8'h0A;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_CSUM_ERR    = 2'd1;
    localparam logic [1:0] ST_STOP_ERR    = 2'd2;
    localparam logic [1:0] ST_LEN_INVALID = 2'd3;

    // Parse phases
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_CMD  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_FCS  = 3'd5,
        PH_STOP = 3'd6
    } phase_t;

    // Fields gathered while a frame is parsed
    typedef struct packed {
        logic [7:0] sum;
        logic [7:0] address;
        logic [7:0] command;
        logic [7:0] length;
        logic [7:0] remaining;
    } frame_t;

    // One result word
    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] frame_address;
        logic [7:0] frame_command;
        logic [7:0] payload_length;
        logic [1:0] frame_status;
        logic       last_of_frame;
    } result_t;

endpackage

@@ rtl/core/mfd_parser.sv @@
// Frame parser: phase register, running checksum and held header fields.
// Produces at most one result word per accepted byte. Depends on mfd_pkg.
module mfd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        rx_byte,
    input  logic              end_of_buffer,
    output logic              res_valid,
    output mfd_pkg::result_t  res
);

    mfd_pkg::phase_t phase_reg, phase_next;
    mfd_pkg::frame_t frame_reg, frame_next, frame_upd, frame_restart;

    logic       has_status;
    logic [1:0] status_code;
    logic       is_payload;
    logic       retry_start;
    logic [7:0] rem_dec;

    assign rem_dec = frame_reg.remaining - 8'd1;

    // A frame seen to begin at this byte: sum seeded with the start byte.
    always_comb begin
        frame_restart     = '0;
        frame_restart.sum = mfd_pkg::SOF_BYTE;
    end

    // Datapath update, status decision and the result word.
    always_comb begin
        frame_upd   = frame_reg;
        has_status  = 1'b0;
        status_code = mfd_pkg::ST_OK;
        is_payload  = 1'b0;
        case (phase_reg)
            mfd_pkg::PH_ADDR: begin
                frame_upd.address = rx_byte;
                frame_upd.sum     = frame_reg.sum + rx_byte;
            end
            mfd_pkg::PH_CMD: begin
                frame_upd.command = rx_byte;
                frame_upd.sum     = frame_reg.sum + rx_byte;
            end
            mfd_pkg::PH_LEN: begin
                frame_upd.length    = rx_byte;
                frame_upd.remaining = rx_byte;
                frame_upd.sum       = frame_reg.sum + rx_byte;
            end
            mfd_pkg::PH_DATA: begin
                frame_upd.sum       = frame_reg.sum + rx_byte;
                frame_upd.remaining = rem_dec;
                is_payload          = 1'b1;
            end
            mfd_pkg::PH_FCS: begin
                // The checksum is not judged on a byte that ends the buffer.
                if (!end_of_buffer && (rx_byte != frame_reg.sum)) begin
                    has_status  = 1'b1;
                    status_code = mfd_pkg::ST_CSUM_ERR;
                end
            end
            mfd_pkg::PH_STOP: begin
                has_status  = 1'b1;
                status_code = (rx_byte == mfd_pkg::STOP_BYTE) ? mfd_pkg::ST_OK
                                                              : mfd_pkg::ST_STOP_ERR;
            end
            default: begin
                if (rx_byte == mfd_pkg::SOF_BYTE) begin
                    frame_upd = frame_restart;
                end
            end
        endcase

        // Buffer ended before the frame completed.
        if (end_of_buffer && !has_status) begin
            has_status  = 1'b1;
            status_code = mfd_pkg::ST_LEN_INVALID;
        end

        // After a checksum or stop error the same byte may open a new frame.
        retry_start = has_status && !end_of_buffer
                      && ((status_code == mfd_pkg::ST_CSUM_ERR)
                          || (status_code == mfd_pkg::ST_STOP_ERR))
                      && (rx_byte == mfd_pkg::SOF_BYTE);

        if (has_status) begin
            frame_next = retry_start ? frame_restart : '0;
        end else begin
            frame_next = frame_upd;
        end

        res_valid          = has_status || is_payload;
        res.kind           = has_status ? mfd_pkg::KIND_STATUS : mfd_pkg::KIND_PAYLOAD;
        res.payload_byte   = has_status ? 8'd0 : rx_byte;
        res.frame_address  = frame_upd.address;
        res.frame_command  = frame_upd.command;
        res.payload_length = frame_upd.length;
        res.frame_status   = has_status ? status_code : mfd_pkg::ST_OK;
        res.last_of_frame  = has_status;
    end

    // Next parse phase.
    always_comb begin
        case (phase_reg)
            mfd_pkg::PH_ADDR: phase_next = mfd_pkg::PH_CMD;
            mfd_pkg::PH_CMD:  phase_next = mfd_pkg::PH_LEN;
            mfd_pkg::PH_LEN: begin
                phase_next = (rx_byte != 8'd0) ? mfd_pkg::PH_DATA : mfd_pkg::PH_FCS;
            end
            mfd_pkg::PH_DATA: begin
                phase_next = (rem_dec == 8'd0) ? mfd_pkg::PH_FCS : mfd_pkg::PH_DATA;
            end
            mfd_pkg::PH_FCS: begin
                phase_next = (rx_byte == frame_reg.sum) ? mfd_pkg::PH_STOP
                                                        : mfd_pkg::PH_FCS;
            end
            mfd_pkg::PH_STOP: phase_next = mfd_pkg::PH_STOP;
            default: begin
                phase_next = (rx_byte == mfd_pkg::SOF_BYTE) ? mfd_pkg::PH_ADDR
                                                            : mfd_pkg::PH_HUNT;
            end
        endcase
        if (has_status) begin
            phase_next = retry_start ? mfd_pkg::PH_ADDR : mfd_pkg::PH_HUNT;
        end
    end

    // State registers advance once per accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mfd_pkg::PH_HUNT;
            frame_reg <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            frame_reg <= frame_next;
        end
    end

endmodule

@@ rtl/core/meter_frame_deframer_top.sv @@
// Meter frame deframer, top level: input handshake, result register.
// Depends on mfd_pkg and mfd_parser.
//
// Usage:
//   The s_ channel takes one received byte per word, with s_end_of_buffer
//   marking the last byte of a receive buffer. The m_ channel gives payload
//   words (m_result_kind = 0) as payload bytes arrive, and one status word
//   (m_result_kind = 1, m_last_of_frame = 1) that closes each frame attempt.
//   Bytes outside a frame give no word unless they end the buffer.
//   Output: a result is registered and shows on m_ in the cycle after its
//   byte is accepted. Throughput: one byte per cycle unless stalled; the
//   parser updates phase, checksum and header fields per accepted byte, the
//   result register holds the word, and the next byte is taken in the cycle that word is taken.
//   Stall: when m_ready is low with a result held, s_ready drops until the
//   result is taken; s_ready follows m_ready in the same cycle.
//   Reset: aresetn (synchronous, active low) returns the parser to hunting
//   for a start byte with all held fields and the checksum at zero, and
//   empties the result register.
module meter_frame_deframer_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_end_of_buffer,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_result_kind,
    output logic [7:0] m_payload_byte,
    output logic [7:0] m_frame_address,
    output logic [7:0] m_frame_command,
    output logic [7:0] m_payload_length,
    output logic [1:0] m_frame_status,
    output logic       m_last_of_frame
);

    logic             accept;
    logic             res_valid;
    mfd_pkg::result_t res;
    mfd_pkg::result_t result_reg;
    logic             m_valid_reg, m_valid_next;

    // Room for a new word when the result register is empty or being taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    mfd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (accept),
        .rx_byte       (s_rx_byte),
        .end_of_buffer (s_end_of_buffer),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Result register occupancy.
    always_comb begin
        if (accept) begin
            m_valid_next = res_valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload is loaded only when a new word is produced.
    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            result_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_kind    = result_reg.kind;
    assign m_payload_byte   = result_reg.payload_byte;
    assign m_frame_address  = result_reg.frame_address;
    assign m_frame_command  = result_reg.frame_command;
    assign m_payload_length = result_reg.payload_length;
    assign m_frame_status   = result_reg.frame_status;
    assign m_last_of_frame  = result_reg.last_of_frame;

    // A byte that ends the buffer always closes with a status word.
    a_eob_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_end_of_buffer) |=> (m_valid && m_result_kind))
        else $error("buffer end did not produce a status word");

    // Status words carry the frame end mark and no payload byte.
    a_status_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == mfd_pkg::KIND_STATUS))
        |-> (m_last_of_frame && (m_payload_byte == 8'd0)))
        else $error("malformed status word");

    // Payload words carry no status and no frame end mark.
    a_payload_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == mfd_pkg::KIND_PAYLOAD))
        |-> (!m_last_of_frame && (m_frame_status == mfd_pkg::ST_OK)))
        else $error("malformed payload word");

    // An empty result register never holds off the input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

endmodule
